@@ src/brb_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Byte ring buffer package
// Shared action codes, control state type and field widths.
// ---------------------------------------------------------------------------
package brb_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned SIZE_W  = 9;
    localparam int unsigned COUNT_W = 9;
    localparam int unsigned ACT_W   = 2;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH  = 2'd0,
        ACT_POP   = 2'd1,
        ACT_PEEK  = 2'd2,
        ACT_CLEAR = 2'd3
    } t_action;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_HOLD = 1'b1
    } t_state;

    // Result of one item before the stored byte is joined in.
    typedef struct packed {
        logic               ok;
        logic               use_rd;
        logic [COUNT_W-1:0] count;
        logic               empty;
        logic               full;
    } t_status;

endpackage

@@ src/brb_ram.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Generic single-clock RAM
// One write port and one read port; read data is registered.
// ---------------------------------------------------------------------------
module brb_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ src/byte_ring_buffer_with_peek.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Byte ring buffer with peek
// A byte FIFO kept in a circular RAM whose wrap point is programmable.
// ---------------------------------------------------------------------------
// Usage:
// Each item on the s_axis channel carries an action in tuser (push, pop,
// peek or clear) and the push byte and peek offset in tdata. Every item
// produces exactly one item on the m_axis channel that reports success,
// the byte read, the fill count and the empty and full flags after the
// action. The wrap size is written through i_cfg_wr_en / i_cfg_wr_data
// while the block is idle; a write also empties the buffer.
// A result passes through the hold stage and then the output register,
// where it drives m_axis_tvalid until the receiver takes it. The block
// takes one item per cycle as long as the receiver keeps m_axis_tready high;
// the single RAM read port, used once per pop or peek, sets that figure.
// When the receiver stalls, one result waits in the output register and a
// second one in the hold stage, after which s_axis_tready drops.
// Reset empties the buffer and sets the wrap size to 256 (limited to
// DEPTH). The RAM itself is not cleared and needs no clearing pass: an
// entry is only ever read after a push has written it.
// ---------------------------------------------------------------------------
module byte_ring_buffer_with_peek #(
    parameter int unsigned DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: wrap size.
    input  logic        i_cfg_wr_en,
    input  logic [8:0]  i_cfg_wr_data,
    // Input items.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // [7:0] push_byte, [15:8] peek_offset
    input  logic [1:0]  s_axis_tuser,  // [1:0] action
    // Result items.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // [7:0] read_byte, [16:8] fill_count,
                                       // [17] is_empty, [18] is_full_now, zero pad
    output logic [0:0]  m_axis_tuser   // [0] ok
);

    localparam int unsigned AW = $clog2(DEPTH);
    // Width that holds a pointer, the size and a pointer plus offset sum.
    localparam int unsigned CW = ((AW > brb_pkg::SIZE_W) ? AW : brb_pkg::SIZE_W) + 1;
    // Largest size the 9-bit register can ask for on this depth.
    localparam logic [brb_pkg::SIZE_W-1:0] SIZE_CAP =
        (DEPTH > 511) ? 9'd511 : brb_pkg::SIZE_W'(DEPTH);
    localparam logic [brb_pkg::SIZE_W-1:0] SIZE_RST =
        (SIZE_CAP < 9'd256) ? SIZE_CAP : 9'd256;

    // Control state.
    brb_pkg::t_state                r_state, n_state;
    logic [brb_pkg::SIZE_W-1:0]     r_size;
    logic [AW-1:0]                  r_wp, n_wp;
    logic [AW-1:0]                  r_rp, n_rp;
    logic [brb_pkg::COUNT_W-1:0]    r_count, n_count;
    logic                           r_o_valid;

    // Payload registers.
    brb_pkg::t_status               r_hold, n_hold;
    logic                           r_o_ok;
    logic [brb_pkg::BYTE_W-1:0]     r_o_byte;
    logic [brb_pkg::COUNT_W-1:0]    r_o_count;
    logic                           r_o_empty;
    logic                           r_o_full;

    // Handshake.
    logic out_free;
    logic accept;
    logic load_out;

    // Item fields.
    brb_pkg::t_action           act;
    logic [brb_pkg::BYTE_W-1:0] push_byte;
    logic [brb_pkg::BYTE_W-1:0] peek_offset;

    // RAM access.
    logic                       ram_wr_en;
    logic                       ram_rd_en;
    logic [AW-1:0]              ram_rd_addr;
    logic [brb_pkg::BYTE_W-1:0] ram_rd_data;

    // Pointer arithmetic.
    logic [CW-1:0]              size_x;
    logic [CW-1:0]              wp_inc;
    logic [CW-1:0]              rp_inc;
    logic [CW-1:0]              peek_sum;
    logic [CW-1:0]              peek_idx;
    logic [brb_pkg::SIZE_W-1:0] cfg_size;

    assign act         = brb_pkg::t_action'(s_axis_tuser);
    assign push_byte   = s_axis_tdata[7:0];
    assign peek_offset = s_axis_tdata[15:8];

    // A result may move into the output register when that register is
    // empty or its item is taken at this edge.
    assign out_free = !r_o_valid || m_axis_tready;
    assign load_out = (r_state == brb_pkg::ST_HOLD) && out_free;
    assign accept   = s_axis_tvalid && s_axis_tready;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            brb_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = brb_pkg::ST_HOLD;
                end
            end
            brb_pkg::ST_HOLD: begin
                if (out_free && !accept) begin
                    n_state = brb_pkg::ST_IDLE;
                end
            end
            default: n_state = brb_pkg::ST_IDLE;
        endcase
    end

    // State outputs: a new item enters when the hold stage is empty or is
    // being emptied into the output register in the same cycle.
    always_comb begin
        s_axis_tready = 1'b0;
        unique case (r_state)
            brb_pkg::ST_IDLE: s_axis_tready = 1'b1;
            brb_pkg::ST_HOLD: s_axis_tready = out_free;
            default:          s_axis_tready = 1'b0;
        endcase
    end

    // Wrapped pointer increments and the peek address.
    assign size_x   = CW'(r_size);
    assign wp_inc   = CW'(r_wp) + CW'(1);
    assign rp_inc   = CW'(r_rp) + CW'(1);
    assign peek_sum = CW'(r_rp) + CW'(peek_offset);
    assign peek_idx = (peek_sum >= size_x) ? (peek_sum - size_x) : peek_sum;

    // Sizes of zero act as one, sizes beyond the depth act as the depth.
    assign cfg_size = (i_cfg_wr_data == '0) ? 9'd1 :
                      (i_cfg_wr_data > SIZE_CAP) ? SIZE_CAP : i_cfg_wr_data;

    // Decide the action against the current pointers and count. The count
    // alone gives full (count equals size) and empty (count is zero).
    always_comb begin
        n_wp        = r_wp;
        n_rp        = r_rp;
        n_count     = r_count;
        ram_wr_en   = 1'b0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = r_rp;
        n_hold.ok     = 1'b0;
        n_hold.use_rd = 1'b0;
        case (act)
            brb_pkg::ACT_PUSH: begin
                if (r_count != r_size) begin
                    n_hold.ok = 1'b1;
                    ram_wr_en = accept;
                    n_wp      = (wp_inc >= size_x) ? '0 : wp_inc[AW-1:0];
                    n_count   = r_count + 9'd1;
                end
            end
            brb_pkg::ACT_POP: begin
                if (r_count != '0) begin
                    n_hold.ok     = 1'b1;
                    n_hold.use_rd = 1'b1;
                    ram_rd_en     = accept;
                    n_rp          = (rp_inc >= size_x) ? '0 : rp_inc[AW-1:0];
                    n_count       = r_count - 9'd1;
                end
            end
            brb_pkg::ACT_PEEK: begin
                if (brb_pkg::COUNT_W'(peek_offset) < r_count) begin
                    n_hold.ok     = 1'b1;
                    n_hold.use_rd = 1'b1;
                    ram_rd_en     = accept;
                    ram_rd_addr   = peek_idx[AW-1:0];
                end
            end
            default: begin
                n_hold.ok = 1'b1;
                n_wp      = '0;
                n_rp      = '0;
                n_count   = '0;
            end
        endcase
        n_hold.count = n_count;
        n_hold.empty = (n_count == '0);
        n_hold.full  = (n_count == r_size);
    end

    brb_ram #(
        .WIDTH (brb_pkg::BYTE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (r_wp),
        .i_wr_data (push_byte),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // Control registers. A size write empties the ring so that both
    // pointers stay below the new size.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= brb_pkg::ST_IDLE;
            r_size    <= SIZE_RST;
            r_wp      <= '0;
            r_rp      <= '0;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_size  <= cfg_size;
                r_wp    <= '0;
                r_rp    <= '0;
                r_count <= '0;
            end else if (accept) begin
                r_wp    <= n_wp;
                r_rp    <= n_rp;
                r_count <= n_count;
            end
            if (load_out) begin
                r_o_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Hold stage and output register. The RAM data belongs to the held
    // item until the next accepted item issues a read, which only happens
    // in the same cycle the held item moves out.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_hold <= n_hold;
        end
        if (load_out) begin
            r_o_ok    <= r_hold.ok;
            r_o_byte  <= r_hold.use_rd ? ram_rd_data : '0;
            r_o_count <= r_hold.count;
            r_o_empty <= r_hold.empty;
            r_o_full  <= r_hold.full;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {5'd0, r_o_full, r_o_empty, r_o_count, r_o_byte};
    assign m_axis_tuser  = r_o_ok;

endmodule

@@ tb/sv/byte_ring_buffer_with_peek_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Byte ring buffer with peek - result checker
// Watches the configuration port and both streams, predicts each result from
// its own copy of the ring and compares it field by field on arrival.
// ---------------------------------------------------------------------------
module byte_ring_buffer_with_peek_checker
    import brb_pkg::*;
#(
    parameter int unsigned DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [8:0]  i_cfg_wr_data,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [15:0] i_s_tdata,     // [7:0] push_byte, [15:8] peek_offset
    input  logic [1:0]  i_s_tuser,     // [1:0] action
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,     // [7:0] read_byte, [16:8] fill_count,
                                       // [17] is_empty, [18] is_full_now
    input  logic [0:0]  i_m_tuser,     // [0] ok
    output int          o_fail_count,
    output int          o_pending,
    output int          o_result_count,
    output logic [8:0]  o_fill_level
);

    typedef struct packed {
        logic               ok;
        logic [BYTE_W-1:0]  read_byte;
        logic [COUNT_W-1:0] fill_count;
        logic               is_empty;
        logic               is_full_now;
    } t_ring_result;

    logic [BYTE_W-1:0] ring_mem [DEPTH];
    logic [7:0]        wr_ptr;
    logic [7:0]        rd_ptr;
    logic              ring_full;
    logic [SIZE_W-1:0] wrap_reg;

    t_ring_result awaited_results [$];
    int           mismatch_total = 0;
    int           results_seen   = 0;
    int           pending_now    = 0;
    logic [8:0]   fill_now       = '0;

    assign o_fail_count   = mismatch_total;
    assign o_pending      = pending_now;
    assign o_result_count = results_seen;
    assign o_fill_level   = fill_now;

    // A size of zero behaves as one, anything above the store depth as the depth.
    function automatic int wrap_span();
        if (wrap_reg == '0) begin
            return 1;
        end
        if (int'(wrap_reg) > int'(DEPTH)) begin
            return int'(DEPTH);
        end
        return int'(wrap_reg);
    endfunction

    function automatic logic [7:0] step_ptr(input logic [7:0] p, input int span);
        int n;
        n = int'(p) + 1;
        return (n >= span) ? 8'd0 : 8'(n);
    endfunction

    function automatic int held_count(input int span);
        if (ring_full) begin
            return span;
        end
        if (wr_ptr >= rd_ptr) begin
            return int'(wr_ptr) - int'(rd_ptr);
        end
        return span - int'(rd_ptr) + int'(wr_ptr);
    endfunction

    // Applies one action to the ring copy and returns the result it must give.
    function automatic t_ring_result apply_ring_action(input t_action act,
                                                       input logic [7:0] pb,
                                                       input logic [7:0] off);
        t_ring_result res;
        int           span;
        int           cnt;
        int           idx;
        span = wrap_span();
        res  = '0;
        case (act)
            ACT_PUSH: begin
                if (!ring_full) begin
                    ring_mem[wr_ptr] = pb;
                    wr_ptr    = step_ptr(wr_ptr, span);
                    ring_full = (wr_ptr == rd_ptr);
                    res.ok    = 1'b1;
                end
            end
            ACT_POP: begin
                if (held_count(span) != 0) begin
                    res.read_byte = ring_mem[rd_ptr];
                    rd_ptr    = step_ptr(rd_ptr, span);
                    ring_full = 1'b0;
                    res.ok    = 1'b1;
                end
            end
            ACT_PEEK: begin
                if (int'(off) < held_count(span)) begin
                    idx = int'(rd_ptr) + int'(off);
                    if (idx >= span) begin
                        idx -= span;
                    end
                    res.read_byte = ring_mem[idx % DEPTH];
                    res.ok = 1'b1;
                end
            end
            default: begin
                wr_ptr    = '0;
                rd_ptr    = '0;
                ring_full = 1'b0;
                res.ok    = 1'b1;
            end
        endcase
        cnt = held_count(span);
        res.fill_count  = cnt[8:0];
        res.is_empty    = (cnt == 0);
        res.is_full_now = (cnt == span);
        return res;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_total++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_ring_result want;
        t_ring_result got;
        if (!i_rst_n) begin
            wr_ptr    = '0;
            rd_ptr    = '0;
            ring_full = 1'b0;
            wrap_reg  = 9'd256;
            awaited_results.delete();
        end else begin
            // The result leaving now can never belong to the item entering now.
            if (i_m_tvalid && i_m_tready) begin
                got.ok          = i_m_tuser[0];
                got.read_byte   = i_m_tdata[7:0];
                got.fill_count  = i_m_tdata[16:8];
                got.is_empty    = i_m_tdata[17];
                got.is_full_now = i_m_tdata[18];
                results_seen++;
                if (awaited_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual ok=%0d byte=%0d count=%0d",
                             $time, got.ok, got.read_byte, got.fill_count);
                    mismatch_total++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("ok", want.ok, got.ok);
                    check_field("read_byte", want.read_byte, got.read_byte);
                    check_field("fill_count", want.fill_count, got.fill_count);
                    check_field("is_empty", want.is_empty, got.is_empty);
                    check_field("is_full_now", want.is_full_now, got.is_full_now);
                end
            end
            // Writing the size empties the ring, just as a clear does.
            if (i_cfg_wr_en) begin
                wrap_reg  = i_cfg_wr_data;
                wr_ptr    = '0;
                rd_ptr    = '0;
                ring_full = 1'b0;
            end
            if (i_s_tvalid && i_s_tready) begin
                awaited_results.push_back(apply_ring_action(t_action'(i_s_tuser),
                                                            i_s_tdata[7:0],
                                                            i_s_tdata[15:8]));
            end
        end
        pending_now = awaited_results.size();
        fill_now    = 9'(held_count(wrap_span()));
    end

endmodule

@@ tb/sv/byte_ring_buffer_with_peek_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Byte ring buffer with peek - testbench top
// Drives directed and random push, pop, peek and clear items across several
// wrap sizes and handshake phases; a separate checker predicts every result.
// ---------------------------------------------------------------------------
module byte_ring_buffer_with_peek_tb;
    import brb_pkg::*;

    localparam int unsigned DEPTH = 256;

    // Without stalls the block keeps accepting items. Even with 80 percent
    // gaps on one side a run of idle cycles this long has a negligible
    // chance, so hitting it means the block has hung.
    localparam int unsigned HANG_LIMIT = 2000;

    // Random phases: wrap size written, number of items, sender gap percent
    // and receiver stall percent. The size list includes zero (acts as one),
    // one, two, the reset value 256 and 511 (acts as the full depth). Only the
    // 511 phase is long, since it has to fill the whole store once.
    localparam int NUM_PHASES = 8;
    localparam logic [8:0] PHASE_WRAP [NUM_PHASES] =
        '{9'd5, 9'd0, 9'd17, 9'd511, 9'd2, 9'd1, 9'd9, 9'd256};
    localparam int PHASE_ITEMS [NUM_PHASES] = '{50, 25, 60, 360, 35, 25, 50, 45};
    localparam int PHASE_IDLE  [4] = '{0, 80, 0, 15};
    localparam int PHASE_STALL [4] = '{0, 0, 80, 15};

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [8:0]  cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [0:0]  m_tuser;

    int          fail_count;
    int          pending;
    int          result_count;
    logic [8:0]  fill_level;

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          items_sent     = 0;
    int          sizes_written  = 0;
    int          quiet_cycles   = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    byte_ring_buffer_with_peek #(
        .DEPTH(DEPTH)
    ) i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser)
    );

    byte_ring_buffer_with_peek_checker #(
        .DEPTH(DEPTH)
    ) u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data),
        .i_s_tvalid     (s_tvalid),
        .i_s_tready     (s_tready),
        .i_s_tdata      (s_tdata),
        .i_s_tuser      (s_tuser),
        .i_m_tvalid     (m_tvalid),
        .i_m_tready     (m_tready),
        .i_m_tdata      (m_tdata),
        .i_m_tuser      (m_tuser),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count),
        .o_fill_level   (fill_level)
    );

    // The receiver makes a fresh ready decision at every falling edge, so the
    // stall pattern is independent of what the sender is doing.
    always @(negedge clk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Every task below is entered and left just after a falling edge. Each one
    // assigns a given input at most once per falling edge, which keeps valid
    // from being dropped and raised in the same time step.

    // Presents one item, after an optional random gap, and holds it until the
    // block takes it at a rising edge.
    task automatic send_item(input t_action act, input logic [7:0] push_byte,
                             input logic [7:0] peek_offset);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {peek_offset, push_byte};
        @(posedge clk);
        while (!s_tready) begin
            @(posedge clk);
        end
        @(negedge clk);
        items_sent++;
    endtask

    // Stops sending and waits until every result in flight has been taken.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0) begin
            @(negedge clk);
        end
    endtask

    // The size may only change while the block is idle; each write also
    // empties the ring.
    task automatic write_wrap_size(input logic [8:0] value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        sizes_written++;
    endtask

    // Random traffic steered toward a moving fill target. Reaching the target
    // of a full or empty ring and pushing past it produces the refused
    // actions; peeks mostly use offsets inside the current count, with a
    // share over the whole byte range. Large rings get fewer peeks and no
    // random clears so that they really do fill up.
    task automatic run_random_phase(input logic [8:0] wrap, input int count,
                                    input int idle_pct, input int stall_pct,
                                    input bit drain_midway);
        int      span;
        int      target;
        int      roll;
        int      peek_pct;
        int      clear_pct;
        t_action act;
        logic [7:0] offset;
        span = (wrap == '0) ? 1 : ((int'(wrap) > int'(DEPTH)) ? int'(DEPTH) : int'(wrap));
        peek_pct  = (span > 32) ? 8 : 22;
        clear_pct = (span > 32) ? 0 : 3;
        write_wrap_size(wrap);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        // Every phase begins by filling the ring.
        target = span;
        for (int k = 0; k < count; k++) begin
            if (drain_midway && k == count / 2) begin
                wait_drained();
            end
            if (int'(fill_level) == target && $urandom_range(99) < 30) begin
                case ($urandom_range(3))
                    0:       target = 0;
                    1:       target = span;
                    default: target = $urandom_range(span);
                endcase
            end
            roll = $urandom_range(99);
            if (roll < clear_pct) begin
                act = ACT_CLEAR;
            end else if (roll < peek_pct) begin
                act = ACT_PEEK;
            end else if (int'(fill_level) < target) begin
                act = (roll < 98) ? ACT_PUSH : ACT_POP;
            end else if (int'(fill_level) > target) begin
                act = (roll < 98) ? ACT_POP : ACT_PUSH;
            end else begin
                act = roll[0] ? ACT_PUSH : ACT_POP;
            end
            if (fill_level != '0 && $urandom_range(3) != 0) begin
                offset = 8'($urandom_range(int'(fill_level) - 1));
            end else begin
                offset = 8'($urandom);
            end
            send_item(act, 8'($urandom), offset);
        end
    endtask

    // Ends the run if nothing at all moves for too long.
    initial begin : watchdog
        while (quiet_cycles < HANG_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("%0t: no handshake for %0d cycles", $time, HANG_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = ACT_PUSH;
        m_tready    = 1'b1;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part at the reset size of 256: refusals on an empty ring,
        // the extreme byte values, peeks inside and outside the count
        // (including the largest offset) and a clear.
        send_item(ACT_POP,   8'($urandom), 8'($urandom));
        send_item(ACT_PEEK,  8'($urandom), 8'd0);
        send_item(ACT_PUSH,  8'h00, 8'($urandom));
        send_item(ACT_PUSH,  8'hFF, 8'($urandom));
        send_item(ACT_PUSH,  8'hA5, 8'($urandom));
        send_item(ACT_PEEK,  8'($urandom), 8'd0);
        send_item(ACT_PEEK,  8'($urandom), 8'd2);
        send_item(ACT_PEEK,  8'($urandom), 8'd3);
        send_item(ACT_PEEK,  8'($urandom), 8'd255);
        send_item(ACT_POP,   8'($urandom), 8'($urandom));
        send_item(ACT_POP,   8'($urandom), 8'($urandom));
        send_item(ACT_CLEAR, 8'($urandom), 8'($urandom));
        send_item(ACT_POP,   8'($urandom), 8'($urandom));

        // A size of zero behaves as a one-entry ring: one push fills it and
        // the next is refused.
        write_wrap_size(9'd0);
        send_item(ACT_PUSH,  8'h5A, 8'($urandom));
        send_item(ACT_PUSH,  8'h11, 8'($urandom));
        send_item(ACT_PEEK,  8'($urandom), 8'd0);
        send_item(ACT_POP,   8'($urandom), 8'($urandom));
        send_item(ACT_POP,   8'($urandom), 8'($urandom));

        // Three entries, which is not a power of two: fill, refuse, then wrap
        // the write pointer and peek across the wrap point.
        write_wrap_size(9'd3);
        send_item(ACT_PUSH,  8'h01, 8'($urandom));
        send_item(ACT_PUSH,  8'h02, 8'($urandom));
        send_item(ACT_PUSH,  8'h03, 8'($urandom));
        send_item(ACT_PUSH,  8'h04, 8'($urandom));
        send_item(ACT_POP,   8'($urandom), 8'($urandom));
        send_item(ACT_PUSH,  8'h05, 8'($urandom));
        send_item(ACT_PEEK,  8'($urandom), 8'd2);

        // Random phases cycle through the four handshake patterns. The first
        // receiver-stall phase also pauses the sender once until the
        // block has handed back every result.
        for (int p = 0; p < NUM_PHASES; p++) begin
            run_random_phase(PHASE_WRAP[p], PHASE_ITEMS[p],
                             PHASE_IDLE[p % 4], PHASE_STALL[p % 4], (p == 2));
        end

        wait_drained();
        // Waiting on past the drain gives any stray result that should not be
        // there the time to show up.
        repeat (8) @(negedge clk);

        $display("Ran %0d items over %0d size settings and checked %0d results.",
                 items_sent, sizes_written, result_count);
        $display("Handshake patterns: free flow, sender gaps, receiver stalls, both mixed.");
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
